/* hw/rtl/row_height_window_finder_assert.svh */
// Assertion macros for the row height window finder.
`ifndef ROW_HEIGHT_WINDOW_FINDER_ASSERT_SVH
`define ROW_HEIGHT_WINDOW_FINDER_ASSERT_SVH
`ifndef SYNTHESIS
`define RHWF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhwf: same-cycle check failed");
`define RHWF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rhwf: next-cycle check failed");
`else
`define RHWF_ASSERT_SAME(lbl, ante, cons)
`define RHWF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/rhwf_pkg.sv */
// Shared constants and codes for the row height window finder.
package rhwf_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int IDX_W       = 10;
	localparam int CNT_W       = 11;
	localparam int SUM_W       = 34;
	localparam int BAND_W      = 11;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_CLOSE = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	// Entry heights: block = BLK_UNIT*(bytes/40+1)+ENTRY_PAD, gap = delta/2+ENTRY_PAD
	localparam int BLK_UNIT    = 20;
	localparam int ENTRY_PAD   = 8;
	localparam int TAIL_HEIGHT = 8;

	// bytes/40 = (bytes>>3)/5; x/5 == (x*RECIP5) >> DIV_SHIFT exactly for x < 2^32
	localparam logic [31:0] RECIP5    = 32'hCCCC_CCCD;
	localparam int          DIV_SHIFT = 34;

endpackage

/* hw/rtl/row_height_window_finder.sv */
// Top level of the row height window finder: command sequencer around the height-sum RAM.
//
// One transaction on the s_ side carries a command in s_tuser and its operands in
// s_tdata; each accepted command yields exactly one result transaction on the m_ side.
// Clear goes straight to the output state, close passes through the close state and add
// through the gap and block states. A query walks the running-sum RAM with two binary
// searches (offset, then span coverage) plus one base read; each search step reads one
// RAM entry, whose registered read data steers the next step.
// Commands are handled one at a time; s_tready is high whenever the sequencer is
// idle, even while a finished result still waits in the output register.
// When m_tready is low, the finished result holds in the output register and the
// next result waits in its final state until the register frees up.
// Reset empties the table (count, total and last end go to zero) and loads the
// oversize limit with 65536; RAM contents are left as they are and entries past
// the count are never read. cfg_we/cfg_wdata write the oversize limit and are
// meant to be used only while no command is in flight.
// Writes happen only for add and close, reads only for query, so RAM accesses
// never overlap on the same entry.
`include "row_height_window_finder_assert.svh"

module row_height_window_finder import rhwf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// range_start[31:0], range_end[63:32], content_length[95:64],
	// view_offset[129:96], view_span[163:130], preload_band[174:164], zero pad
	input  logic [175:0] s_tdata,
	// command[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// window_first[9:0], window_last[19:10], window_valid[20], oversized[21],
	// overflow[22], entry_count[33:23], total_height[67:34], zero pad
	output logic [71:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_GAP   = 3'd1;
	localparam logic [2:0] ST_BLK   = 3'd2;
	localparam logic [2:0] ST_CLOSE = 3'd3;
	localparam logic [2:0] ST_SRCH  = 3'd4;
	localparam logic [2:0] ST_BASE  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] total_q;
	logic [31:0]      prev_q;
	logic [31:0]      limit_q;
	logic             m_tvalid_q;
	logic [71:0]      m_tdata_q;

	logic [31:0]       rs_q, re_q, clen_q, bytes_q;
	logic [SUM_W-1:0]  vspan_q;
	logic [BAND_W-1:0] band_q;
	logic              valid_q, over_q, ovf_q;
	logic [60:0]       prod_s1;

	logic [CNT_W-1:0] lo_q, hi_q;
	logic [IDX_W-1:0] mid_q, first_q, last_q;
	logic             pend_q, phase_q;
	logic [SUM_W:0]   key_q;

	logic             accept;
	logic [1:0]       in_cmd;
	logic [31:0]      in_rs, in_re;

	logic             app_en, drop, ram_we;
	logic [31:0]      app_h, gap_h, blk_h;
	logic [26:0]      blk_q;
	logic [SUM_W:0]   sum_w;
	logic [SUM_W-1:0] sum_sat;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [SUM_W-1:0] rd_data;
	logic             hit, done, need_base;
	logic [CNT_W-1:0] lo_n, hi_n, mid_w, res_c;
	logic [IDX_W-1:0] mid_n, res_idx;

	logic [CNT_W-1:0] wf_w;
	logic [CNT_W:0]   wl_sum, wl_lim, wl_w;
	logic [IDX_W-1:0] wf, wl;
	logic             out_load;

	assign in_cmd   = s_tuser;
	assign in_rs    = s_tdata[31:0];
	assign in_re    = s_tdata[63:32];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// Entry heights
	assign gap_h = ((rs_q - prev_q) >> 1) + 32'(ENTRY_PAD);
	assign blk_q = prod_s1[60:DIV_SHIFT];
	assign blk_h = (32'(blk_q) << 4) + (32'(blk_q) << 2) + 32'(BLK_UNIT + ENTRY_PAD);

	always_comb begin
		app_en = 1'b0;
		app_h  = '0;
		case (state_q)
			ST_GAP: begin
				app_en = rs_q > prev_q;
				app_h  = gap_h;
			end
			ST_BLK: begin
				app_en = 1'b1;
				app_h  = blk_h;
			end
			ST_CLOSE: begin
				app_en = prev_q < clen_q;
				app_h  = 32'(TAIL_HEIGHT);
			end
			default: ;
		endcase
	end

	// Saturating append at the current count
	assign drop    = !(count_q < CNT_W'(MAX_ENTRIES));
	assign ram_we  = app_en && !drop;
	assign sum_w   = {1'b0, total_q} + (SUM_W + 1)'(app_h);
	assign sum_sat = sum_w[SUM_W] ? {SUM_W{1'b1}} : sum_w[SUM_W-1:0];

	// One binary search step per cycle: first entry with sum > key in [lo, hi)
	always_comb begin
		hit  = {1'b0, rd_data} > key_q;
		lo_n = lo_q;
		hi_n = hi_q;
		if (pend_q) begin
			if (hit) begin
				hi_n = CNT_W'(mid_q);
			end else begin
				lo_n = CNT_W'(mid_q) + CNT_W'(1);
			end
		end
		done      = !(lo_n < hi_n);
		mid_w     = lo_n + ((hi_n - lo_n) >> 1);
		mid_n     = mid_w[IDX_W-1:0];
		res_c     = (lo_n < count_q) ? lo_n : count_q - CNT_W'(1);
		res_idx   = res_c[IDX_W-1:0];
		need_base = !phase_q && (vspan_q != '0) && (res_idx != '0);
		rd_en     = (state_q == ST_SRCH) && (!done || need_base);
		rd_addr   = done ? res_idx - IDX_W'(1) : mid_n;
	end

	// Widen by the preload band and clamp to the table
	always_comb begin
		wf_w   = ({1'b0, first_q} > band_q) ? CNT_W'(first_q) - band_q : '0;
		wl_sum = (CNT_W + 1)'(last_q) + (CNT_W + 1)'(band_q);
		wl_lim = (CNT_W + 1)'(count_q - CNT_W'(1));
		wl_w   = (wl_sum > wl_lim) ? wl_lim : wl_sum;
		wf     = valid_q ? wf_w[IDX_W-1:0] : '0;
		wl     = valid_q ? wl_w[IDX_W-1:0] : '0;
	end

	rhwf_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_ENTRIES)
	) u_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(sum_sat),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			total_q    <= '0;
			prev_q     <= '0;
			limit_q    <= 32'd65536;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (ram_we) begin
				count_q <= count_q + CNT_W'(1);
				total_q <= sum_sat;
			end
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
								prev_q  <= '0;
								state_q <= ST_OUT;
							end
							CMD_ADD:   state_q <= ST_GAP;
							CMD_CLOSE: state_q <= ST_CLOSE;
							CMD_QUERY: state_q <= (count_q != '0) ? ST_SRCH : ST_OUT;
							default:   state_q <= ST_OUT;
						endcase
					end
				end
				ST_GAP: state_q <= ST_BLK;
				ST_BLK: begin
					prev_q  <= re_q;
					state_q <= ST_OUT;
				end
				ST_CLOSE: state_q <= ST_OUT;
				ST_SRCH: begin
					if (done) begin
						if (phase_q || vspan_q == '0) begin
							state_q <= ST_OUT;
						end else if (need_base) begin
							state_q <= ST_BASE;
						end
					end
				end
				ST_BASE: state_q <= ST_SRCH;
				ST_OUT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= bytes_q[31:3] * RECIP5;
		if (accept) begin
			rs_q    <= in_rs;
			re_q    <= in_re;
			clen_q  <= s_tdata[95:64];
			vspan_q <= s_tdata[163:130];
			band_q  <= s_tdata[174:164];
			bytes_q <= (in_re >= in_rs) ? in_re - in_rs : '0;
			valid_q <= (in_cmd == CMD_QUERY) && (count_q != '0);
			over_q  <= 1'b0;
			ovf_q   <= 1'b0;
			lo_q    <= '0;
			hi_q    <= count_q;
			pend_q  <= 1'b0;
			phase_q <= 1'b0;
			key_q   <= {1'b0, s_tdata[129:96]};
		end
		if (app_en && drop) begin
			ovf_q <= 1'b1;
		end
		if (state_q == ST_BLK) begin
			over_q <= bytes_q > limit_q;
		end
		if (state_q == ST_SRCH) begin
			if (!done) begin
				lo_q   <= lo_n;
				hi_q   <= hi_n;
				mid_q  <= mid_n;
				pend_q <= 1'b1;
			end else if (phase_q) begin
				last_q <= res_idx;
			end else begin
				first_q <= res_idx;
				last_q  <= IDX_W'(count_q - CNT_W'(1));
				if (!need_base) begin
					// first entry is the base: coverage counts from zero
					key_q   <= {1'b0, vspan_q} - (SUM_W + 1)'(1);
					lo_q    <= CNT_W'(res_idx);
					hi_q    <= count_q;
					pend_q  <= 1'b0;
					phase_q <= 1'b1;
				end
			end
		end
		if (state_q == ST_BASE) begin
			// covered >= span  <=>  sum > base + span - 1
			key_q   <= {1'b0, rd_data} + {1'b0, vspan_q} - (SUM_W + 1)'(1);
			lo_q    <= CNT_W'(first_q);
			hi_q    <= count_q;
			pend_q  <= 1'b0;
			phase_q <= 1'b1;
		end
		if (out_load) begin
			m_tdata_q <= {4'b0, total_q, count_q, ovf_q, over_q, valid_q, wl, wf};
		end
	end

	`RHWF_ASSERT_SAME(a_we_only_on_append,
		ram_we, (state_q == ST_GAP || state_q == ST_BLK || state_q == ST_CLOSE))
	`RHWF_ASSERT_SAME(a_read_below_count, rd_en, ({1'b0, rd_addr} < count_q))
	`RHWF_ASSERT_NEXT(a_append_counts, ram_we, (count_q == $past(count_q) + CNT_W'(1)))
	`RHWF_ASSERT_NEXT(a_accept_leaves_idle, accept, (state_q != ST_IDLE))

endmodule

/* hw/rtl/rhwf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rhwf_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sim/tb_row_height_window_finder.sv */
// Self-checking testbench for the row height window finder with a predicting scoreboard.
module tb_row_height_window_finder;
	import rhwf_pkg::*;

	localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 1;

	typedef struct packed {
		logic [BAND_W-1:0] preload_band;
		logic [SUM_W-1:0]  view_span;
		logic [SUM_W-1:0]  view_offset;
		logic [31:0]       content_length;
		logic [31:0]       range_end;
		logic [31:0]       range_start;
	} request_t;

	typedef struct packed {
		logic [SUM_W-1:0] total_height;
		logic [CNT_W-1:0] entry_count;
		logic             overflow;
		logic             oversized;
		logic             window_valid;
		logic [IDX_W-1:0] window_last;
		logic [IDX_W-1:0] window_first;
	} result_t;

	// Keeps its own copy of the height table and predicts one result per command.
	class height_window_checker;
		longint unsigned sums[MAX_ENTRIES];
		int unsigned     count;
		longint unsigned total;
		longint unsigned prev_end;
		longint unsigned limit;
		result_t         expected_results[$];
		int              errors;

		function new();
			count = 0;
			total = 0;
			prev_end = 0;
			limit = 65536;
			errors = 0;
		endfunction

		// Return 1 when the entry does not fit and is dropped.
		function bit append_entry(longint unsigned h);
			longint unsigned t;
			if (count >= MAX_ENTRIES)
				return 1'b1;
			t = total + h;
			if (t > SUM_MAX)
				t = SUM_MAX;
			total = t;
			sums[count[IDX_W-1:0]] = t;
			count++;
			return 1'b0;
		endfunction

		function void note_command(logic [1:0] cmd, request_t req);
			result_t         res;
			longint unsigned bytes, covered, band, rs, re;
			int unsigned     lo, hi, mid, first, last, i, n;
			bit              dropped;
			res = '0;
			rs = 64'(req.range_start);
			re = 64'(req.range_end);
			band = 64'(req.preload_band);
			case (cmd)
				CMD_CLEAR: begin
					count = 0;
					total = 0;
					prev_end = 0;
				end
				CMD_ADD: begin
					bytes = (re >= rs) ? re - rs : 0;
					dropped = 1'b0;
					if (rs > prev_end)
						dropped = append_entry((rs - prev_end) / 2 + ENTRY_PAD);
					res.oversized = bytes > limit;
					if (append_entry(BLK_UNIT * (bytes / 40 + 1) + ENTRY_PAD))
						dropped = 1'b1;
					res.overflow = dropped;
					prev_end = re;
				end
				CMD_CLOSE: begin
					if (prev_end < 64'(req.content_length))
						res.overflow = append_entry(64'(TAIL_HEIGHT));
				end
				default: begin
					if (count != 0) begin
						n = count;
						lo = 0;
						hi = n;
						while (lo < hi) begin
							mid = lo + (hi - lo) / 2;
							if (sums[mid[IDX_W-1:0]] > 64'(req.view_offset))
								hi = mid;
							else
								lo = mid + 1;
						end
						first = (lo < n) ? lo : n - 1;
						last = n - 1;
						i = first;
						covered = 0;
						// walk until the span is covered; a zero span keeps the last entry
						while (i < n && covered < 64'(req.view_span)) begin
							covered += sums[i[IDX_W-1:0]] -
								((i != 0) ? sums[IDX_W'(i - 1)] : 64'd0);
							last = i;
							i++;
						end
						first = (64'(first) > band) ? first - 32'(band) : 0;
						last = (64'(last) + band > 64'(n - 1)) ? n - 1 : last + 32'(band);
						res.window_first = first[IDX_W-1:0];
						res.window_last = last[IDX_W-1:0];
						res.window_valid = 1'b1;
					end
				end
			endcase
			res.entry_count = count[CNT_W-1:0];
			res.total_height = total[SUM_W-1:0];
			expected_results = {expected_results, res};
		endfunction

		function void check_result(logic [71:0] data);
			result_t got, want;
			got = data[$bits(result_t)-1:0];
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transaction: %h", got);
				return;
			end
			want = expected_results.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("expected first=%0d last=%0d vld=%0b ovs=%0b ovf=%0b cnt=%0d tot=%0d",
						want.window_first, want.window_last, want.window_valid, want.oversized,
						want.overflow, want.entry_count, want.total_height);
					$display("actual   first=%0d last=%0d vld=%0b ovs=%0b ovf=%0b cnt=%0d tot=%0d",
						got.window_first, got.window_last, got.window_valid, got.oversized,
						got.overflow, got.entry_count, got.total_height);
				end
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [175:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	logic         cfg_we;
	logic [31:0]  cfg_wdata;

	height_window_checker table_chk;
	bit                   idle_on;

	row_height_window_finder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("== FAIL ==");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic [SUM_W-1:0] rand34();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[SUM_W-1:0];
	endfunction

	function automatic request_t make_request(logic [31:0] rs, logic [31:0] re,
			logic [31:0] clen, logic [SUM_W-1:0] voff, logic [SUM_W-1:0] vspan,
			logic [BAND_W-1:0] band);
		request_t req;
		req.range_start = rs;
		req.range_end = re;
		req.content_length = clen;
		req.view_offset = voff;
		req.view_span = vspan;
		req.preload_band = band;
		return req;
	endfunction

	// Random fields, then the fields the command uses shaped to follow the table state.
	function automatic request_t build_request(logic [1:0] cmd, bit force_gap);
		request_t        req;
		longint unsigned base, tot;
		int              pick;
		req = make_request($urandom, $urandom, $urandom, rand34(), rand34(),
			BAND_W'($urandom_range(0, 1024)));
		if (!force_gap && $urandom_range(0, 9) == 0)
			return req;
		base = table_chk.prev_end;
		tot = table_chk.total;
		case (cmd)
			CMD_ADD: begin
				pick = $urandom_range(0, 9);
				if (force_gap)
					req.range_start = 32'(base + 1 + $urandom_range(0, 300));
				else if (pick < 4)
					req.range_start = 32'(base);
				else if (pick < 9)
					req.range_start = 32'(base + $urandom_range(1, 300));
				pick = $urandom_range(0, 19);
				if (pick < 14)
					req.range_end = req.range_start + $urandom_range(0, 400);
				else if (pick < 18)
					req.range_end = req.range_start + $urandom_range(60000, 70000);
				else if (pick == 18)
					req.range_end = req.range_start - $urandom_range(1, 50);
			end
			CMD_CLOSE: begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					req.content_length = 32'(base + $urandom_range(1, 500));
				else if (pick < 7)
					req.content_length = 32'(base);
			end
			CMD_QUERY: begin
				if (tot != 0 && $urandom_range(0, 9) < 8)
					req.view_offset = SUM_W'(rand34() % (tot + 1));
				pick = $urandom_range(0, 9);
				if (pick < 3)
					req.view_span = '0;
				else if (pick < 8)
					req.view_span = SUM_W'(rand34() % (tot / 16 + 1));
				if ($urandom_range(0, 9) < 6)
					req.preload_band = BAND_W'($urandom_range(0, 4));
			end
			default: ;
		endcase
		return req;
	endfunction

	task automatic send_item(logic [1:0] cmd, request_t req);
		int gap;
		gap = (idle_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {1'b0, req};
		do @(posedge clk); while (!s_tready);
		table_chk.note_command(cmd, req);
	endtask

	// Hold off until every result is back and the sequencer has settled.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (table_chk.expected_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_limit(logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		table_chk.limit = 64'(value);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int items, int w_clear, int w_add, int w_close, bit force_gap);
		logic [1:0] cmd;
		int         roll;
		for (int k = 0; k < items; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < w_clear)
				cmd = CMD_CLEAR;
			else if (roll < w_clear + w_add)
				cmd = CMD_ADD;
			else if (roll < w_clear + w_add + w_close)
				cmd = CMD_CLOSE;
			else
				cmd = CMD_QUERY;
			send_item(cmd, build_request(cmd, force_gap));
		end
	endtask

	// Result side: check each transaction, then stall at random.
	initial begin
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				table_chk.check_result(m_tdata);
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 99) < 25) begin
				stall = pick_gap() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		table_chk = new();
		idle_on = 1'b1;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_CLEAR;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, bounds of the limit, end before start, tail, queries
		send_item(CMD_QUERY, make_request(0, 0, 0, 0, 0, 0));
		send_item(CMD_CLOSE, make_request(0, 0, 0, 0, 0, 0));
		send_item(CMD_ADD, make_request(0, 0, 0, 0, 0, 0));
		send_item(CMD_ADD, make_request(100, 40, 0, 0, 0, 0));
		send_item(CMD_ADD, make_request(40, 40 + 65536, 0, 0, 0, 0));
		send_item(CMD_ADD, make_request(65576, 65576 + 65537, 0, 0, 0, 0));
		send_item(CMD_CLOSE, make_request(0, 0, 32'hFFFF_FFFF, 0, 0, 0));
		send_item(CMD_CLOSE, make_request(0, 0, 5, 0, 0, 0));
		send_item(CMD_QUERY, make_request(0, 0, 0, 0, 0, 0));
		send_item(CMD_QUERY, make_request(0, 0, 0, '1, '1, 1024));
		send_item(CMD_QUERY, make_request(0, 0, 0, 60, 1, 1));
		send_item(CMD_QUERY, make_request(0, 0, 0, 0, 30, 1023));
		send_item(CMD_CLEAR, make_request(0, 0, 0, 0, 0, 0));
		// drive the running total into saturation with huge gaps
		repeat (9) send_item(CMD_ADD, make_request(32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		send_item(CMD_QUERY, make_request(0, 0, 0, 34'h3_0000_0000, 1, 0));
		send_item(CMD_ADD, make_request(0, 400, 0, 0, 0, 0));
		drain();

		write_limit(32'd0);
		run_random(60, 6, 50, 14, 1'b0);
		drain();

		// fill the table past its capacity, first without idling
		write_limit(32'hFFFF_FFFF);
		idle_on = 1'b0;
		send_item(CMD_CLEAR, make_request(0, 0, 0, 0, 0, 0));
		run_random(250, 0, 88, 4, 1'b1);
		idle_on = 1'b1;
		run_random(350, 0, 88, 4, 1'b1);
		drain();

		write_limit($urandom);
		run_random(50, 3, 30, 20, 1'b0);
		drain();

		write_limit(32'd65536);
		run_random(25, 5, 45, 15, 1'b0);
		drain();

		if (table_chk.errors == 0 && table_chk.expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
